// ===== src/rsp_pkg.sv =====
package rsp_pkg;

  localparam int MAX_PARITY   = 32;
  localparam int CNT_W        = $clog2(MAX_PARITY + 1);
  localparam int IDX_W        = $clog2(MAX_PARITY);
  localparam int CFG_W        = 6;
  localparam int PARITY_RESET = 7;
  localparam logic [8:0] GF_POLY = 9'h11D;

  typedef logic [7:0] gf_t;

  // per-cycle commands broadcast along the cell chain
  typedef struct packed {
    logic init;    // seed generator coefficient, clear remainder
    logic round;   // multiply generator by (x + root)
    logic absorb;  // take one message byte
    logic flush;   // final byte: copy remainder to drain, clear remainder
    logic shift;   // advance drain chain by one byte
  } cell_ctl_t;

  function automatic gf_t gf_xtime(input gf_t a);
    logic [8:0] t;
    t = {a, 1'b0};
    if (t[8]) begin
      t = t ^ GF_POLY;
    end
    return t[7:0];
  endfunction

  function automatic gf_t gf_mul(input gf_t x, input gf_t y);
    gf_t a;
    gf_t p;
    a = x;
    p = '0;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) begin
        p = p ^ a;
      end
      a = gf_xtime(a);
    end
    return p;
  endfunction

endpackage

// ===== src/rsp_cell.sv =====
// One stage of the generator / remainder / drain chain.
module rsp_cell (
  input  logic              clk,
  input  rsp_pkg::cell_ctl_t ctl,
  input  logic              active,
  input  rsp_pkg::gf_t      g_seed,
  input  rsp_pkg::gf_t      root,
  input  rsp_pkg::gf_t      fb,
  input  rsp_pkg::gf_t      lo_g,
  input  rsp_pkg::gf_t      lo_rem,
  input  rsp_pkg::gf_t      lo_drain,
  output rsp_pkg::gf_t      g_out,
  output rsp_pkg::gf_t      rem_out,
  output rsp_pkg::gf_t      drain_out
);

  rsp_pkg::gf_t g_r;
  rsp_pkg::gf_t rem_r;
  rsp_pkg::gf_t drain_r;
  rsp_pkg::gf_t rem_nxt;

  assign rem_nxt = lo_rem ^ rsp_pkg::gf_mul(fb, g_r);

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      g_r   <= g_seed;
      rem_r <= '0;
    end else begin
      if (ctl.round && active) begin
        g_r <= lo_g ^ rsp_pkg::gf_mul(g_r, root);
      end
      if (ctl.absorb && active) begin
        rem_r <= ctl.flush ? 8'h00 : rem_nxt;
      end
    end
  end

  // load wins over shift: the last queued byte leaves in the same cycle
  always_ff @(posedge clk) begin
    if (ctl.absorb && ctl.flush && active) begin
      drain_r <= rem_nxt;
    end else if (ctl.shift) begin
      drain_r <= lo_drain;
    end
  end

  assign g_out     = g_r;
  assign rem_out   = rem_r;
  assign drain_out = drain_r;

endmodule

// ===== src/reed_solomon_parity_encoder_top.sv =====
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D.
// cfg_data sets the parity count n (0 reads as 1, values above 32 saturate to
// 32); after reset n is 7. The generator g(x) = (x+a^0)...(x+a^(n-1)) is built
// by the cell chain one factor per cycle, and while it is built after reset or a
// cfg transaction the block holds in_stall high and cfg_ready low. Message bytes
// then enter at one per cycle: every cell updates its remainder byte in parallel.
// A byte with in_is_final set is absorbed, the n parity bytes move as a group
// into a drain chain and leave highest degree first, one per out transaction,
// with out_parity_last on the final one. The next message streams in while
// the drain empties; only a final byte that arrives before the previous parity
// group has drained waits, so a message of at least n bytes sustains one byte
// per cycle while out_stall is low. A cfg write discards any message in progress.
module reed_solomon_parity_encoder_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [rsp_pkg::CFG_W-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_is_final,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_parity_byte,
  output logic                    out_parity_last
);

  localparam int MAXP  = rsp_pkg::MAX_PARITY;
  localparam int CNT_W = rsp_pkg::CNT_W;
  localparam int IDX_W = rsp_pkg::IDX_W;

  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] build_cnt_r, build_cnt_nxt;
  logic [CNT_W-1:0] drain_cnt_r, drain_cnt_nxt;
  rsp_pkg::gf_t     root_r, root_nxt;

  logic             building;
  logic             cfg_fire;
  logic             in_fire;
  logic             out_fire;
  logic             drain_free;
  logic [IDX_W-1:0] top_idx;
  rsp_pkg::gf_t     fb;
  rsp_pkg::cell_ctl_t ctl;

  rsp_pkg::gf_t g_w     [MAXP];
  rsp_pkg::gf_t rem_w   [MAXP];
  rsp_pkg::gf_t drain_w [MAXP];

  // saturate the written parity count into 1..MAX_PARITY
  logic [CNT_W-1:0] n_cfg;
  always_comb begin
    if (cfg_data == '0) begin
      n_cfg = CNT_W'(1);
    end else if (int'(cfg_data) > MAXP) begin
      n_cfg = CNT_W'(MAXP);
    end else begin
      n_cfg = CNT_W'(cfg_data);
    end
  end

  assign building   = (build_cnt_r != '0);
  assign cfg_ready  = ~building;
  assign cfg_fire   = cfg_valid & cfg_ready;

  // drain chain empties, or its last byte leaves this cycle
  assign drain_free = (drain_cnt_r == '0) ||
                      ((drain_cnt_r == CNT_W'(1)) && !out_stall);
  assign in_stall   = building | (in_is_final & ~drain_free);
  assign in_fire    = in_valid & ~in_stall;

  assign out_valid  = (drain_cnt_r != '0);
  assign out_fire   = out_valid & ~out_stall;

  assign top_idx         = IDX_W'(n_r - CNT_W'(1));
  assign fb              = in_data_byte ^ rem_w[top_idx];
  assign out_parity_byte = drain_w[top_idx];
  assign out_parity_last = (drain_cnt_r == CNT_W'(1));

  always_comb begin
    ctl.init   = ~rst_n | cfg_fire;
    ctl.round  = building;
    ctl.absorb = in_fire;
    ctl.flush  = in_is_final;
    ctl.shift  = out_fire;
  end

  // generator build: one factor per cycle, root advances by alpha
  always_comb begin
    n_nxt         = n_r;
    build_cnt_nxt = build_cnt_r;
    root_nxt      = root_r;
    if (cfg_fire) begin
      n_nxt         = n_cfg;
      build_cnt_nxt = n_cfg;
      root_nxt      = 8'h01;
    end else if (building) begin
      build_cnt_nxt = build_cnt_r - CNT_W'(1);
      root_nxt      = rsp_pkg::gf_xtime(root_r);
    end
  end

  // drain count: load n on a final byte, drop one per out transaction
  always_comb begin
    drain_cnt_nxt = drain_cnt_r;
    if (in_fire && in_is_final) begin
      drain_cnt_nxt = n_r;
    end else if (out_fire) begin
      drain_cnt_nxt = drain_cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= CNT_W'(rsp_pkg::PARITY_RESET);
      build_cnt_r <= CNT_W'(rsp_pkg::PARITY_RESET);
      root_r      <= 8'h01;
      drain_cnt_r <= '0;
    end else begin
      n_r         <= n_nxt;
      build_cnt_r <= build_cnt_nxt;
      root_r      <= root_nxt;
      drain_cnt_r <= drain_cnt_nxt;
    end
  end

  // cell chain: cell 0 sees zeros below it, only cells below n build, absorb and load
  for (genvar j = 0; j < MAXP; j++) begin : g_cell
    rsp_pkg::gf_t lo_g, lo_rem, lo_drain;
    logic         active;

    if (j == 0) begin : g_first
      assign lo_g     = '0;
      assign lo_rem   = '0;
      assign lo_drain = '0;
    end else begin : g_rest
      assign lo_g     = g_w[j-1];
      assign lo_rem   = rem_w[j-1];
      assign lo_drain = drain_w[j-1];
    end

    assign active = (CNT_W'(j) < n_r);

    rsp_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .active    (active),
      .g_seed    ((j == 0) ? 8'h01 : 8'h00),
      .root      (root_r),
      .fb        (fb),
      .lo_g      (lo_g),
      .lo_rem    (lo_rem),
      .lo_drain  (lo_drain),
      .g_out     (g_w[j]),
      .rem_out   (rem_w[j]),
      .drain_out (drain_w[j])
    );
  end

endmodule
